>>> hw/rtl/ibt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibt_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS = 7;

  localparam logic [STATUS_BITS-1:0] STATUS_BOOKED  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERLAP = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] req_start;
    logic [FIELD_BITS-1:0] req_end;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  booked_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ibt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ibt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ibt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ibt_ctrl
  import ibt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads go out one entry a cycle; the last compare lands as the scan ends.
        if (sts.scan_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/ibt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ibt_dp
  import ibt_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int unsigned TW = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [TW-1:0]     rq_start;
  logic [TW-1:0]     rq_end;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     count;
  logic              overlap;
  logic              cmp_vld;
  logic [2*TW-1:0]   rd_data;
  logic [TW-1:0]     slot_start;
  logic [TW-1:0]     slot_end;
  logic              hit;
  logic              full;
  logic              book;
  logic [CW-1:0]     count_next;
  logic [CW+6:0]     count_wide;

  // Entries are never released, so entries 0 to count-1 are exactly the
  // valid ones and the lowest free entry is always at count.
  assign full       = (count == CW'(DEPTH));
  assign book       = !overlap && !full;
  assign count_next = book ? count + 1'b1 : count;
  assign count_wide = (CW + 7)'(count_next);

  assign slot_start = rd_data[2*TW-1:TW];
  assign slot_end   = rd_data[TW-1:0];
  assign hit        = !((rq_end <= slot_start) || (rq_start >= slot_end));

  assign sts.scan_done = (idx == count);
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  ibt_ram #(
    .WIDTH (2 * TW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.fin && book),
    .wr_addr (count[AW-1:0]),
    .wr_data ({rq_start, rq_end}),
    .rd_en   (cmd.rd),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_start <= req.req_start[TW-1:0];
      rq_end   <= req.req_end[TW-1:0];
    end
    if (cmd.fin) begin
      rsp.status       <= overlap ? STATUS_OVERLAP : (full ? STATUS_FULL : STATUS_BOOKED);
      rsp.booked_count <= count_wide[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      count     <= '0;
      overlap   <= 1'b0;
      cmp_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cmp_vld <= cmd.rd;
      if (cmd.load) begin
        idx     <= '0;
        overlap <= 1'b0;
      end else begin
        if (cmd.rd) begin
          idx <= idx + 1'b1;
        end
        if (cmp_vld && hit) begin
          overlap <= 1'b1;
        end
      end
      if (cmd.fin) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/interval_booking_table_unit.sv
// The result is registered after the request transfer, a scan of the N intervals
// already stored (at most DEPTH), and a wait while the previous result is still
// held by rsp_stall.
// A new request is taken only after the last result is written; the table RAM is read one entry a
// cycle to check for overlap.
// Reset (synchronous, active high) empties the table at once through the fill count.
`timescale 1ns / 1ps
`default_nettype none

module interval_booking_table_unit
  import ibt_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  ibt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ibt_dp #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // Once a request transfers, no other is taken until its result is produced.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a lookup was in progress");

  // The scan never reads beyond the filled part of the table.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> !sts.scan_done)
    else $error("table read past the fill count");

  // A result is only written when the output register can take it.
  a_fin_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> sts.out_free)
    else $error("result written over a pending transfer");

  // A new result shows up only after the controller finished a request.
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.fin))
    else $error("result appeared without a finished request");
`endif

endmodule

`default_nettype wire

>>> tb/interval_booking_table_unit_tb.sv
`timescale 1ns / 1ps

module interval_booking_table_unit_tb;
  import ibt_pkg::*;

  localparam int unsigned TBL_DEPTH = 64;
  localparam int unsigned TBL_TIME_BITS = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  rsp_t want_rsp;

  // Shadow of the reservation table, updated at every request transfer.
  logic [FIELD_BITS-1:0] bk_start[TBL_DEPTH];
  logic [FIELD_BITS-1:0] bk_end[TBL_DEPTH];
  logic bk_used[TBL_DEPTH];

  // Intervals the stimulus generator has aimed at free time, used to build overlaps.
  logic [FIELD_BITS-1:0] plan_start[$];
  logic [FIELD_BITS-1:0] plan_end[$];
  logic [FIELD_BITS-1:0] fresh_cursor = 1000;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int unsigned cycle_count = 0;

  interval_booking_table_unit #(
    .DEPTH(TBL_DEPTH),
    .TIME_BITS(TBL_TIME_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_t predict_booking(req_t r);
    rsp_t res;
    logic hit;
    int free_slot;
    int unsigned n;
    hit = 1'b0;
    free_slot = -1;
    n = 0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (bk_used[i]) begin
        n++;
        if (!(r.req_end <= bk_start[i] || r.req_start >= bk_end[i])) hit = 1'b1;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit) begin
      res.status = STATUS_OVERLAP;
    end else if (free_slot < 0) begin
      res.status = STATUS_FULL;
    end else begin
      bk_start[free_slot] = r.req_start;
      bk_end[free_slot] = r.req_end;
      bk_used[free_slot] = 1'b1;
      n++;
      res.status = STATUS_BOOKED;
    end
    res.booked_count = n[COUNT_BITS-1:0];
    return res;
  endfunction

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) bk_used[i] = 1'b0;
  end

  // Request driver: the prediction is taken at the transfer itself.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) expected_rsps.insert(expected_rsps.size(), predict_booking(req));
      if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result status=%0d booked_count=%0d", $time,
                   rsp.status, rsp.booked_count);
          errors++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp.status !== want_rsp.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want_rsp.status, rsp.status);
            errors++;
          end
          if (rsp.booked_count !== want_rsp.booked_count) begin
            $display("%0t: booked_count mismatch: expected %0d, actual %0d", $time,
                     want_rsp.booked_count, rsp.booked_count);
            errors++;
          end
        end
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic [FIELD_BITS-1:0] s, input logic [FIELD_BITS-1:0] e);
    req_t r;
    r.req_start = s;
    r.req_end = e;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Mostly requests that collide with earlier ones, a steady trickle that lands in
  // free time so the table fills over the run, and some full-range noise.
  task automatic queue_random_requests(input int n);
    int pick;
    int p;
    logic [FIELD_BITS-1:0] s;
    logic [FIELD_BITS-1:0] e;
    logic [FIELD_BITS-1:0] ps;
    logic [FIELD_BITS-1:0] pe;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 9 || plan_start.size() == 0) begin
        s = fresh_cursor + $urandom_range(0, 3);
        e = s + $urandom_range(1, 40);
        fresh_cursor = e;
        plan_start.insert(plan_start.size(), s);
        plan_end.insert(plan_end.size(), e);
      end else if (pick < 17) begin
        s = $urandom;
        e = $urandom;
      end else begin
        p = $urandom_range(plan_start.size() - 1);
        ps = plan_start[p];
        pe = plan_end[p];
        case ($urandom_range(5))
          0: begin
            s = pe;
            e = pe + $urandom_range(1, 40);
          end
          1: begin
            e = ps;
            s = ps - $urandom_range(1, 40);
          end
          2: begin
            s = ps - $urandom_range(0, 5);
            e = pe + $urandom_range(0, 5);
          end
          3: begin
            s = ps;
            e = ps + 1;
          end
          4: begin
            s = pe - 1;
            e = pe;
          end
          default: begin
            s = ps + $urandom_range(pe - ps - 1);
            e = s + $urandom_range(1, 60);
          end
        endcase
      end
      push_req(s, e);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int n, input int snd_pct, input int rcv_pct);
    @(negedge clk);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    queue_random_requests(n);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty and reversed intervals, touching edges and the extremes of the time range.
    push_req(32'h0000_0000, 32'h0000_0000);
    push_req(32'h0000_0000, 32'h0000_0000);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(32'd10, 32'd20);
    push_req(32'd15, 32'd25);
    push_req(32'd20, 32'd30);
    push_req(32'd5, 32'd10);
    push_req(32'd9, 32'd11);
    push_req(32'd19, 32'd21);
    push_req(32'h0000_0000, 32'hFFFF_FFFF);
    push_req(32'd25, 32'd15);
    push_req(32'hFFFF_FFFF, 32'h0000_0000);
    push_req(32'h8000_0000, 32'h8000_0001);
    push_req(32'h7FFF_FFFF, 32'h8000_0001);
    push_req(32'h8000_0000, 32'h8000_0000);
    push_req(32'd0, 32'd1);
    push_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    wait_drained();

    run_phase(190, 0, 0);
    run_phase(190, 74, 0);
    run_phase(190, 0, 74);
    run_phase(190, 35, 35);

    // Long receiver hold-off while requests keep coming, so the input backs up.
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    @(posedge clk);
    hold_left <= HOLD_OFF_CYCLES;
    @(negedge clk);
    queue_random_requests(50);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
